/* rtl/ffsa_pkg.sv */
// ----------------------------------------------------------------------------
// ffsa_pkg
// Types and constants shared by the first-fit segment allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package ffsa_pkg;

    localparam int FFSA_MEM_BYTES    = 1024;
    localparam int FFSA_MAX_SEGMENTS = 32;

    // request and result field widths
    localparam int REQ_SIZE_W = 11;
    localparam int BLK_ADDR_W = 10;
    localparam int STATUS_W   = 2;

    typedef enum logic {
        CMD_ALLOC = 1'b0,
        CMD_FREE  = 1'b1
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK         = 2'd0,
        STATUS_NO_FIT     = 2'd1,
        STATUS_TABLE_FULL = 2'd2,
        STATUS_NOT_FOUND  = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_SCAN,
        ST_SHIFT,
        ST_WR_LO,
        ST_WR_HI,
        ST_DONE
    } state_t;

endpackage

`default_nettype wire

/* rtl/first_fit_segment_allocator.sv */
// ----------------------------------------------------------------------------
// first_fit_segment_allocator
// Ordered segment table with first-fit allocate (split on partial fit) and
// free by start address. Freed segments are not merged.
// ----------------------------------------------------------------------------
// One request at a time. The table lives in a one-write, one-read memory of
// MAX_SEGMENTS entries with registered read data, and that single read port
// sets the pace: a request walks the table one entry per cycle, stopping at
// the first match or after the last of the n current entries. An allocate
// that splits at entry i then moves the n - i - 1 entries behind the hit up
// by one, one per cycle, and then writes the shrunk entry and the new tail
// entry. An allocate of size zero answers with no-fit without walking the
// table. After reset the block writes the initial whole-memory entry in
// ST_INIT before s_tready rises. The result sits in an output register; the
// block takes the next request while it waits.
// ----------------------------------------------------------------------------
`default_nettype none

module first_fit_segment_allocator #(
    parameter int MEM_BYTES    = ffsa_pkg::FFSA_MEM_BYTES,
    parameter int MAX_SEGMENTS = ffsa_pkg::FFSA_MAX_SEGMENTS
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // [10:0] request_size, [20:11] block_address
    input  wire logic [0:0]  s_tuser,   // [0] command
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata    // [9:0] granted_address, [11:10] status
);
    import ffsa_pkg::*;

    localparam int AW = (MEM_BYTES > 1) ? $clog2(MEM_BYTES) : 1;   // start offset
    localparam int SW = $clog2(MEM_BYTES + 1);                      // segment size
    localparam int EW = 1 + SW + AW;                                // used, size, start
    localparam int IW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
    localparam int CW = $clog2(MAX_SEGMENTS + 1);
    localparam int KW = (SW > REQ_SIZE_W) ? SW : REQ_SIZE_W;
    localparam int KA = (AW > BLK_ADDR_W) ? AW : BLK_ADDR_W;

    // segment table
    logic [EW-1:0] seg_mem [MAX_SEGMENTS];
    logic [EW-1:0] rd_data_reg;

    logic          we_c;
    logic [IW-1:0] wa_c;
    logic [EW-1:0] wd_c;
    logic [IW-1:0] ra_c;

    state_t                 state_reg, state_next;
    logic [CW-1:0]          n_reg, n_next;
    cmd_t                   cmd_reg, cmd_next;
    logic [REQ_SIZE_W-1:0]  req_reg, req_next;
    logic [BLK_ADDR_W-1:0]  addr_reg, addr_next;
    logic [CW-1:0]          scan_idx_reg, scan_idx_next;
    logic                   chk_vld_reg, chk_vld_next;
    logic [IW-1:0]          chk_idx_reg, chk_idx_next;
    logic [IW-1:0]          hit_idx_reg, hit_idx_next;
    logic [AW-1:0]          hit_start_reg, hit_start_next;
    logic [SW-1:0]          hit_size_reg, hit_size_next;
    logic [AW-1:0]          tail_reg, tail_next;
    logic [CW-1:0]          sh_k_reg, sh_k_next;
    logic                   pend_reg, pend_next;
    logic [IW-1:0]          pend_dst_reg, pend_dst_next;
    logic [BLK_ADDR_W-1:0]  res_addr_reg, res_addr_next;
    status_t                res_status_reg, res_status_next;
    logic                   m_tvalid_reg, m_tvalid_next;
    logic [15:0]            m_tdata_reg, m_tdata_next;

    logic [AW-1:0] rd_start;
    logic [SW-1:0] rd_size;
    logic          rd_used;
    logic [KW-1:0] rd_size_ext;
    logic [KW-1:0] req_ext;
    logic [KA-1:0] rd_start_ext;
    logic [KA-1:0] addr_ext;
    logic [KA-1:0] tail_ext;
    logic          alloc_hit;
    logic          free_hit;
    logic          chk_last;
    logic [CW-1:0] sh_km1;
    logic [SW-1:0] lo_size;

    assign rd_start     = rd_data_reg[AW-1:0];
    assign rd_size      = rd_data_reg[AW +: SW];
    assign rd_used      = rd_data_reg[EW-1];
    assign rd_size_ext  = KW'(rd_size);
    assign req_ext      = KW'(req_reg);
    assign rd_start_ext = KA'(rd_start);
    assign addr_ext     = KA'(addr_reg);
    assign tail_ext     = KA'(tail_reg);
    assign alloc_hit    = !rd_used && (rd_size_ext >= req_ext);
    assign free_hit     = (rd_start_ext == addr_ext);
    assign chk_last     = ((CW'(chk_idx_reg) + CW'(1)) == n_reg);
    assign sh_km1       = sh_k_reg - CW'(1);
    assign lo_size      = hit_size_reg - SW'(req_reg);

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // table memory: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (we_c) begin
            seg_mem[wa_c] <= wd_c;
        end
        rd_data_reg <= seg_mem[ra_c];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_INIT;
            n_reg        <= CW'(1);
            chk_vld_reg  <= 1'b0;
            pend_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            n_reg        <= n_next;
            chk_vld_reg  <= chk_vld_next;
            pend_reg     <= pend_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg        <= cmd_next;
        req_reg        <= req_next;
        addr_reg       <= addr_next;
        scan_idx_reg   <= scan_idx_next;
        chk_idx_reg    <= chk_idx_next;
        hit_idx_reg    <= hit_idx_next;
        hit_start_reg  <= hit_start_next;
        hit_size_reg   <= hit_size_next;
        tail_reg       <= tail_next;
        sh_k_reg       <= sh_k_next;
        pend_dst_reg   <= pend_dst_next;
        res_addr_reg   <= res_addr_next;
        res_status_reg <= res_status_next;
        m_tdata_reg    <= m_tdata_next;
    end

    always_comb begin
        state_next      = state_reg;
        n_next          = n_reg;
        cmd_next        = cmd_reg;
        req_next        = req_reg;
        addr_next       = addr_reg;
        scan_idx_next   = scan_idx_reg;
        chk_vld_next    = chk_vld_reg;
        chk_idx_next    = chk_idx_reg;
        hit_idx_next    = hit_idx_reg;
        hit_start_next  = hit_start_reg;
        hit_size_next   = hit_size_reg;
        tail_next       = tail_reg;
        sh_k_next       = sh_k_reg;
        pend_next       = pend_reg;
        pend_dst_next   = pend_dst_reg;
        res_addr_next   = res_addr_reg;
        res_status_next = res_status_reg;
        m_tvalid_next   = m_tvalid_reg;
        m_tdata_next    = m_tdata_reg;

        we_c = 1'b0;
        wa_c = '0;
        wd_c = '0;
        ra_c = scan_idx_reg[IW-1:0];

        // drop the output word once taken
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            ST_INIT: begin
                // one free segment over the whole memory
                we_c       = 1'b1;
                wa_c       = '0;
                wd_c       = {1'b0, SW'(MEM_BYTES), AW'(0)};
                state_next = ST_IDLE;
            end

            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd_next        = cmd_t'(s_tuser[0]);
                    req_next        = s_tdata[REQ_SIZE_W-1:0];
                    addr_next       = s_tdata[REQ_SIZE_W +: BLK_ADDR_W];
                    scan_idx_next   = '0;
                    chk_vld_next    = 1'b0;
                    res_addr_next   = '0;
                    res_status_next = STATUS_OK;
                    if ((cmd_t'(s_tuser[0]) == CMD_ALLOC) &&
                        (s_tdata[REQ_SIZE_W-1:0] == '0)) begin
                        res_status_next = STATUS_NO_FIT;
                        state_next      = ST_DONE;
                    end else begin
                        state_next = ST_SCAN;
                    end
                end
            end

            ST_SCAN: begin
                if (chk_vld_reg && (cmd_reg == CMD_FREE) && free_hit) begin
                    we_c       = 1'b1;
                    wa_c       = chk_idx_reg;
                    wd_c       = {1'b0, rd_size, rd_start};
                    state_next = ST_DONE;
                end else if (chk_vld_reg && (cmd_reg == CMD_ALLOC) && alloc_hit) begin
                    hit_idx_next   = chk_idx_reg;
                    hit_start_next = rd_start;
                    hit_size_next  = rd_size;
                    if (rd_size_ext == req_ext) begin
                        we_c          = 1'b1;
                        wa_c          = chk_idx_reg;
                        wd_c          = {1'b1, rd_size, rd_start};
                        res_addr_next = rd_start_ext[BLK_ADDR_W-1:0];
                        state_next    = ST_DONE;
                    end else if (n_reg == CW'(MAX_SEGMENTS)) begin
                        res_status_next = STATUS_TABLE_FULL;
                        state_next      = ST_DONE;
                    end else begin
                        sh_k_next  = n_reg;
                        pend_next  = 1'b0;
                        state_next = ST_SHIFT;
                    end
                end else if (chk_vld_reg && chk_last) begin
                    res_status_next = (cmd_reg == CMD_FREE) ? STATUS_NOT_FOUND
                                                            : STATUS_NO_FIT;
                    state_next      = ST_DONE;
                end else if (scan_idx_reg < n_reg) begin
                    // advance the read one entry ahead of the compare
                    ra_c          = scan_idx_reg[IW-1:0];
                    chk_vld_next  = 1'b1;
                    chk_idx_next  = scan_idx_reg[IW-1:0];
                    scan_idx_next = scan_idx_reg + CW'(1);
                end else begin
                    chk_vld_next = 1'b0;
                end
            end

            ST_SHIFT: begin
                // move entries up by one, from the end down to just past the hit
                if (pend_reg) begin
                    we_c = 1'b1;
                    wa_c = pend_dst_reg;
                    wd_c = rd_data_reg;
                end
                if (sh_k_reg > (CW'(hit_idx_reg) + CW'(1))) begin
                    ra_c          = sh_km1[IW-1:0];
                    pend_next     = 1'b1;
                    pend_dst_next = sh_k_reg[IW-1:0];
                    sh_k_next     = sh_km1;
                end else begin
                    pend_next  = 1'b0;
                    state_next = ST_WR_LO;
                end
            end

            ST_WR_LO: begin
                we_c       = 1'b1;
                wa_c       = hit_idx_reg;
                wd_c       = {1'b0, lo_size, hit_start_reg};
                tail_next  = hit_start_reg + AW'(lo_size);
                state_next = ST_WR_HI;
            end

            ST_WR_HI: begin
                we_c          = 1'b1;
                wa_c          = hit_idx_reg + IW'(1);
                wd_c          = {1'b1, SW'(req_reg), tail_reg};
                n_next        = n_reg + CW'(1);
                res_addr_next = tail_ext[BLK_ADDR_W-1:0];
                state_next    = ST_DONE;
            end

            ST_DONE: begin
                // hold until the output register is free
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {4'b0000, res_status_reg, res_addr_reg};
                    state_next    = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

/* tb/first_fit_segment_allocator_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// first_fit_segment_allocator_test
// Sends allocate and free words to the allocator and compares each result
// word with a mirror of the segment table kept in this module. The mirror
// advances on every accepted request. Directed checks come first, then a
// random mix on a fragmented and full table, with random idling on both sides.
// ----------------------------------------------------------------------------
module first_fit_segment_allocator_test;

    import ffsa_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_WORDS   = 1560;

    typedef struct {
        logic [BLK_ADDR_W-1:0] granted;
        status_t               status;
    } grant_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata  = '0;
    logic [0:0]  s_tuser  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;

    // mirror of the segment table
    logic [BLK_ADDR_W-1:0] seg_start [FFSA_MAX_SEGMENTS];
    logic [REQ_SIZE_W-1:0] seg_size  [FFSA_MAX_SEGMENTS];
    bit                    seg_used  [FFSA_MAX_SEGMENTS];
    int                    seg_count;

    grant_t pending_grants [$];
    int     mismatches    = 0;
    int     idle_cycles   = 0;
    bit     tx_idle       = 1'b1;
    bit     rx_idle       = 1'b1;
    int     rx_stall_req  = 0;
    int     rx_stall_left = 0;
    int     rx_gap_left   = 0;

    first_fit_segment_allocator DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),   // [10:0] request_size, [20:11] block_address
        .s_tuser  (s_tuser),   // [0] command
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)    // [9:0] granted_address, [11:10] status
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Apply one request to the mirror and return the grant it should produce.
    function automatic grant_t apply_request(cmd_t cmd, logic [REQ_SIZE_W-1:0] size,
                                             logic [BLK_ADDR_W-1:0] addr);
        grant_t g;
        int     hit;
        int     k;
        int     n;
        g.granted = '0;
        g.status  = STATUS_OK;
        n         = seg_count;
        hit       = -1;
        if (cmd == CMD_ALLOC) begin
            for (k = 0; k < n; k++)
                if (hit < 0 && !seg_used[k] && seg_size[k] >= size)
                    hit = k;
            if (size == 0 || hit < 0) begin
                g.status = STATUS_NO_FIT;
            end else if (seg_size[hit] == size) begin
                seg_used[hit] = 1'b1;
                g.granted     = seg_start[hit];
            end else if (n >= FFSA_MAX_SEGMENTS) begin
                g.status = STATUS_TABLE_FULL;
            end else begin
                // open a slot behind the hit, then carve the tail off it
                for (k = n; k > hit + 1; k--) begin
                    seg_start[k] = seg_start[k-1];
                    seg_size[k]  = seg_size[k-1];
                    seg_used[k]  = seg_used[k-1];
                end
                seg_size[hit]     = seg_size[hit] - size;
                seg_start[hit+1]  = seg_start[hit] + seg_size[hit][BLK_ADDR_W-1:0];
                seg_size[hit+1]   = size;
                seg_used[hit+1]   = 1'b1;
                seg_count         = n + 1;
                g.granted         = seg_start[hit+1];
            end
        end else begin
            for (k = 0; k < n; k++)
                if (hit < 0 && seg_start[k] == addr)
                    hit = k;
            if (hit < 0)
                g.status = STATUS_NOT_FOUND;
            else
                seg_used[hit] = 1'b0;
        end
        return g;
    endfunction

    function automatic int idle_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 3);
        else if (r < 95)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Offer one word, hold it until accepted, then advance the mirror.
    task automatic send_request(cmd_t cmd, logic [REQ_SIZE_W-1:0] size,
                                logic [BLK_ADDR_W-1:0] addr);
        int gap;
        gap = 0;
        if (tx_idle && $urandom_range(0, 1) == 1)
            gap = idle_length();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {3'b000, addr, size};
        do @(posedge aclk); while (!s_tready);
        pending_grants.push_back(apply_request(cmd, size, addr));
    endtask

    // Stop offering and wait until every expected result has come back.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending_grants.size() != 0);
    endtask

    // Mostly well-formed requests against the current table, some noise.
    task automatic send_mixed_request();
        int                    r;
        int                    idx;
        int                    tries;
        logic [REQ_SIZE_W-1:0] size;
        logic [BLK_ADDR_W-1:0] addr;
        r    = $urandom_range(0, 99);
        size = REQ_SIZE_W'($urandom_range(0, 2047));
        addr = BLK_ADDR_W'($urandom_range(0, 1023));
        if (r < 35) begin
            size = REQ_SIZE_W'($urandom_range(1, 64));
            for (tries = 0; tries < 8; tries++) begin
                idx = $urandom_range(0, seg_count - 1);
                if (!seg_used[idx]) begin
                    size = seg_size[idx];
                    break;
                end
            end
            send_request(CMD_ALLOC, size, addr);
        end else if (r < 50) begin
            send_request(CMD_ALLOC, REQ_SIZE_W'($urandom_range(1, 64)), addr);
        end else if (r < 55) begin
            send_request(CMD_ALLOC, size, addr);
        end else if (r < 90) begin
            idx = $urandom_range(0, seg_count - 1);
            send_request(CMD_FREE, size, seg_start[idx]);
        end else begin
            send_request(CMD_FREE, size, addr);
        end
    endtask

    task automatic test_size_limits();
        send_request(CMD_ALLOC, 11'd0, 10'd0);
        send_request(CMD_ALLOC, 11'd1025, 10'd1023);
        send_request(CMD_ALLOC, 11'd2047, 10'd512);
        send_request(CMD_FREE, 11'd2047, 10'd0);     // free of a block already free
        send_request(CMD_FREE, 11'd0, 10'd1023);     // no such start
    endtask

    task automatic test_exact_fit();
        send_request(CMD_ALLOC, 11'd1024, 10'd0);
        send_request(CMD_ALLOC, 11'd1, 10'd0);       // nothing free left
        send_request(CMD_FREE, 11'd0, 10'd0);
        send_request(CMD_FREE, 11'd0, 10'd0);
    endtask

    task automatic test_split();
        send_request(CMD_ALLOC, 11'd1, 10'd0);
        send_request(CMD_ALLOC, 11'd512, 10'd0);
        send_request(CMD_ALLOC, 11'd510, 10'd0);
        send_request(CMD_ALLOC, 11'd1, 10'd0);
        send_request(CMD_FREE, 11'd0, 10'd511);
        send_request(CMD_ALLOC, 11'd512, 10'd0);
        send_request(CMD_FREE, 11'd0, 10'd1023);
        send_request(CMD_FREE, 11'd0, 10'd1);
        send_request(CMD_FREE, 11'd0, 10'd0);
        send_request(CMD_FREE, 11'd0, 10'd512);
    endtask

    task automatic test_table_full();
        int guard;
        int idx;
        int k;
        guard = 0;
        while (seg_count < FFSA_MAX_SEGMENTS && guard < 100) begin
            send_request(CMD_ALLOC, REQ_SIZE_W'($urandom_range(1, 16)),
                         BLK_ADDR_W'($urandom_range(0, 1023)));
            guard++;
        end
        // a request that must split the first free entry large enough
        idx = -1;
        for (k = 0; k < seg_count; k++)
            if (idx < 0 && !seg_used[k] && seg_size[k] >= 2)
                idx = k;
        if (idx >= 0) begin
            send_request(CMD_ALLOC, seg_size[idx] - 11'd1, 10'd0);
            send_request(CMD_ALLOC, seg_size[idx], 10'd0);
        end
    endtask

    task automatic test_backpressure();
        int i;
        wait_drained();
        tx_idle      = 1'b0;
        rx_stall_req = 300;
        for (i = 0; i < 30; i++)
            send_mixed_request();
        tx_idle = 1'b1;
    endtask

    task automatic test_random_mix();
        int i;
        for (i = 0; i < RANDOM_WORDS; i++) begin
            if (i % 100 == 0) begin
                tx_idle = $urandom_range(0, 3) != 0;
                rx_idle = $urandom_range(0, 3) != 0;
            end
            // let the pipe run dry now and then
            if (i % 250 == 249)
                wait_drained();
            send_mixed_request();
        end
    endtask

    initial begin
        for (int k = 0; k < FFSA_MAX_SEGMENTS; k++) begin
            seg_start[k] = '0;
            seg_size[k]  = '0;
            seg_used[k]  = 1'b0;
        end
        seg_size[0] = REQ_SIZE_W'(FFSA_MEM_BYTES);
        seg_count   = 1;

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        test_size_limits();
        test_exact_fit();
        test_split();
        test_table_full();
        test_backpressure();
        test_random_mix();

        wait_drained();
        repeat (100) @(posedge aclk);
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // receiver: random gaps, plus a long hold when a test asks for one
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (rx_stall_req > 0) begin
                rx_stall_left = rx_stall_req;
                rx_stall_req  = 0;
            end
            if (rx_stall_left > 0) begin
                rx_stall_left = rx_stall_left - 1;
                m_tready <= 1'b0;
            end else if (rx_gap_left > 0) begin
                rx_gap_left = rx_gap_left - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                if (rx_idle && $urandom_range(0, 99) < 25)
                    rx_gap_left = idle_length();
            end
        end
    end

    always @(posedge aclk) begin : check_results
        grant_t expected;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_grants.size() == 0) begin
                $error("result word with nothing outstanding: granted_address %0d status %0d",
                       m_tdata[9:0], m_tdata[11:10]);
                mismatches++;
            end else begin
                expected = pending_grants.pop_front();
                if (m_tdata[9:0] !== expected.granted) begin
                    $error("granted_address: expected %0d, actual %0d",
                           expected.granted, m_tdata[9:0]);
                    mismatches++;
                end
                if (m_tdata[11:10] !== expected.status) begin
                    $error("status: expected %s, actual %0d",
                           expected.status.name(), m_tdata[11:10]);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("status: fail");
                $finish;
            end
        end
    end

endmodule
